// ===== sv/lcdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdfs_pkg
// Shared types, panel geometry and a helper function of the LCD frame store.
// ----------------------------------------------------------------------------
package lcdfs_pkg;

    // Panel geometry.
    localparam int PANEL_COLUMNS = 128;
    localparam int PANEL_ROWS    = 64;
    localparam int CTRL_COLUMNS  = 64;
    localparam int CTRL_ROWS     = 64;

    localparam int PAGES        = PANEL_ROWS / 8;
    localparam int MEM_DEPTH    = PANEL_COLUMNS * PAGES;
    localparam int NUM_CTRL     = (PANEL_COLUMNS + CTRL_COLUMNS - 1) / CTRL_COLUMNS;
    localparam int PANEL_PIXELS = PANEL_COLUMNS * PANEL_ROWS;

    // Derived widths.
    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam int CTRL_W = (NUM_CTRL > 1) ? $clog2(NUM_CTRL) : 1;
    localparam int BAL_W  = $clog2(PANEL_PIXELS) + 1;
    localparam int COL_W  = 7;
    localparam int LINE_W = 6;
    localparam int MUL_W  = COL_W + 4;
    localparam int CMP_W  = 10;

    // Reset values.
    localparam logic [7:0] BACKLIGHT_RESET = 8'd16;
    localparam logic signed [BAL_W-1:0] BALANCE_RESET = BAL_W'(-(PANEL_PIXELS / 2));

    // Limits of the reported balance field.
    localparam int SAT_MIN = -8192;
    localparam int SAT_MAX = 8191;

    // Item kinds carried on the input tuser.
    typedef enum logic [2:0] {
        ACT_WRITE     = 3'd0,
        ACT_ENABLE    = 3'd1,
        ACT_START     = 3'd2,
        ACT_READ      = 3'd3,
        ACT_BACKLIGHT = 3'd4
    } action_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Input word, last field in the lowest bits.
    typedef struct packed {
        logic [7:0] backlight_in;
        logic [5:0] screen_line;
        logic [5:0] start_line;
        logic       enable;
        logic       controller;
        logic [7:0] byte_data;
        logic [2:0] page;
        logic [6:0] column;
    } in_word_t;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [2:0]        pad;
        logic [7:0]        backlight_level;
        logic              light_on_dark;
        logic              redraw;
        logic signed [13:0] pixel_balance;
        logic [3:0]        changed_bits;
        logic              pixel;
    } out_word_t;

    // Scroll start lines of all controllers.
    typedef logic [NUM_CTRL-1:0][5:0] start_vec_t;

    // Frame memory access decoded from one item.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              wr_ok;
        logic              rd_ok;
        logic [2:0]        bit_idx;
        logic [CTRL_W-1:0] ctrl;
    } mem_access_t;

    // Number of set bits in a byte.
    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

endpackage

// ===== sv/lcdfs_frame_ram.sv =====
// ----------------------------------------------------------------------------
// lcdfs_frame_ram
// Single-port-write, registered-read frame memory with a clearing pass that
// zeroes every entry after reset.
// ----------------------------------------------------------------------------
module lcdfs_frame_ram
    import lcdfs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    output logic              clr_busy
);

    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;

    // The clearing pass walks the memory one entry per cycle.
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // Write port: clearing pass first, then item writes.
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= 8'd0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// ===== sv/lcdfs_addr_gen.sv =====
// ----------------------------------------------------------------------------
// lcdfs_addr_gen
// Maps an item's column, page and screen line to a frame memory entry and a
// bit within it, applying the owning controller's scroll start line.
// ----------------------------------------------------------------------------
module lcdfs_addr_gen
    import lcdfs_pkg::*;
(
    input  action_t      action,
    input  in_word_t     item,
    input  start_vec_t   starts,
    output mem_access_t  acc
);

    logic [CTRL_W-1:0] ctrl;
    logic [5:0]        row;
    logic [MUL_W-1:0]  col_base;
    logic              col_ok;
    logic              page_ok;
    logic              line_ok;
    logic              row_ok;

    // Owning controller: count the controller boundaries left of the column.
    always_comb begin
        ctrl = '0;
        for (int i = 1; i < NUM_CTRL; i++) begin
            if ({3'b000, item.column} >= CMP_W'(i * CTRL_COLUMNS)) begin
                ctrl = CTRL_W'(i);
            end
        end
    end

    // Stored row shown on the screen line, wrapping at the controller height.
    assign row      = item.screen_line + starts[ctrl];
    assign col_base = MUL_W'(item.column) * MUL_W'(PAGES);

    assign col_ok  = {3'b000, item.column} < CMP_W'(PANEL_COLUMNS);
    assign page_ok = {7'd0, item.page} < CMP_W'(PAGES);
    assign line_ok = {4'd0, item.screen_line} < CMP_W'(PANEL_ROWS);
    assign row_ok  = {4'd0, row} < CMP_W'(PANEL_ROWS);

    // Pick the entry; out-of-panel accesses point at entry zero.
    always_comb begin
        acc.ctrl    = ctrl;
        acc.wr_ok   = col_ok && page_ok;
        acc.rd_ok   = col_ok && line_ok && row_ok;
        acc.bit_idx = row[2:0];
        acc.addr    = '0;
        if (action == ACT_WRITE) begin
            if (acc.wr_ok) begin
                acc.addr = ADDR_W'(col_base + MUL_W'(item.page));
            end
        end else if (acc.rd_ok) begin
            acc.addr = ADDR_W'(col_base + MUL_W'(row[5:3]));
        end
    end

endmodule

// ===== sv/lcd_frame_store_with_scroll_core.sv =====
// ----------------------------------------------------------------------------
// lcd_frame_store_with_scroll_core
// An accepted word's frame memory read is registered; in the execute state,
// once the output register is free, the modify and write-back take place and
// the result word is registered. No new word is taken before that happens.
// Reset: aresetn clears all control state; a clearing pass then zeroes the
// frame memory, during which s_tready stays low.
// ----------------------------------------------------------------------------
module lcd_frame_store_with_scroll_core
    import lcdfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // column[6:0], page[9:7], byte_data[17:10], controller[18], enable[19],
    // start_line[25:20], screen_line[31:26], backlight_in[39:32]
    input  logic [39:0] s_tdata,
    // action[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel[0], changed_bits[4:1], pixel_balance[18:5], redraw[19],
    // light_on_dark[20], backlight_level[28:21], zero[31:29]
    output logic [31:0] m_tdata
);

    state_t      state_reg, state_next;
    in_word_t    in_word;
    mem_access_t acc_in;

    // Item held during its execute cycle.
    in_word_t    item_reg;
    action_t     act_reg;
    mem_access_t acc_reg;

    // Panel state.
    logic [NUM_CTRL-1:0]       en_reg, en_next;
    start_vec_t                start_reg, start_next;
    logic signed [BAL_W-1:0]   bal_reg, bal_next;
    logic [7:0]                bl_reg, bl_next;

    // Output register.
    logic      m_tvalid_reg, m_tvalid_next;
    out_word_t out_reg, out_next;

    // Memory interface.
    logic       accept;
    logic       load;
    logic       mem_wr_en;
    logic [7:0] mem_rd_data;
    logic       clr_busy;

    logic [3:0]        pop_old, pop_new, changed;
    logic signed [4:0] delta;
    logic [CTRL_W-1:0] ctrl_idx;
    logic              ctrl_ok;
    logic              pixel;
    logic              redraw;

    assign in_word  = in_word_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    lcdfs_addr_gen u_addr_gen (
        .action (action_t'(s_tuser)),
        .item   (in_word),
        .starts (start_reg),
        .acc    (acc_in)
    );

    lcdfs_frame_ram u_frame_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (acc_in.addr),
        .rd_data  (mem_rd_data),
        .wr_en    (mem_wr_en),
        .wr_addr  (acc_reg.addr),
        .wr_data  (item_reg.byte_data),
        .clr_busy (clr_busy)
    );

    // Capture the word while its memory read is under way.
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_word;
            act_reg  <= action_t'(s_tuser);
            acc_reg  <= acc_in;
        end
    end

    // Bit counts of the stored and the new byte.
    assign pop_old  = popcount8(mem_rd_data);
    assign pop_new  = popcount8(item_reg.byte_data);
    assign delta    = $signed({1'b0, pop_new}) - $signed({1'b0, pop_old});
    assign ctrl_idx = CTRL_W'(item_reg.controller);
    assign ctrl_ok  = 32'(item_reg.controller) < NUM_CTRL;

    // Sequencer and the execute cycle's modify logic.
    always_comb begin
        state_next    = state_reg;
        en_next       = en_reg;
        start_next    = start_reg;
        bal_next      = bal_reg;
        bl_next       = bl_reg;
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        mem_wr_en     = 1'b0;
        changed       = 4'd0;
        pixel         = 1'b0;
        redraw        = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                if (!clr_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (load) begin
                    unique case (act_reg)
                        ACT_WRITE: begin
                            if (acc_reg.wr_ok) begin
                                mem_wr_en = 1'b1;
                                changed   = popcount8(mem_rd_data ^ item_reg.byte_data);
                                bal_next  = bal_reg + BAL_W'(delta);
                                redraw    = (changed != 4'd0);
                            end
                        end
                        ACT_ENABLE: begin
                            if (ctrl_ok && en_reg[ctrl_idx] != item_reg.enable) begin
                                en_next[ctrl_idx] = item_reg.enable;
                                redraw            = 1'b1;
                            end
                        end
                        ACT_START: begin
                            if (ctrl_ok && start_reg[ctrl_idx] != item_reg.start_line) begin
                                start_next[ctrl_idx] = item_reg.start_line;
                                redraw               = 1'b1;
                            end
                        end
                        ACT_READ: begin
                            pixel = acc_reg.rd_ok && en_reg[acc_reg.ctrl] &&
                                    mem_rd_data[acc_reg.bit_idx];
                        end
                        ACT_BACKLIGHT: begin
                            if (bl_reg != item_reg.backlight_in) begin
                                bl_next = item_reg.backlight_in;
                                redraw  = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase

                    // Assemble the result from the updated state.
                    out_next.pad             = 3'd0;
                    out_next.pixel           = pixel;
                    out_next.changed_bits    = changed;
                    out_next.redraw          = redraw;
                    out_next.backlight_level = bl_next;
                    out_next.light_on_dark   = (bal_next < 0) || !(&en_next);
                    if (int'(bal_next) < SAT_MIN) begin
                        out_next.pixel_balance = 14'(SAT_MIN);
                    end else if (int'(bal_next) > SAT_MAX) begin
                        out_next.pixel_balance = 14'(SAT_MAX);
                    end else begin
                        out_next.pixel_balance = 14'(bal_next);
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control and panel state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            en_reg       <= '0;
            start_reg    <= '0;
            bal_reg      <= BALANCE_RESET;
            bl_reg       <= BACKLIGHT_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            en_reg       <= en_next;
            start_reg    <= start_next;
            bal_reg      <= bal_next;
            bl_reg       <= bl_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // No word is taken while the memory is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !clr_busy)
        else $error("input word accepted during the clearing pass");

    // Memory writes happen only when an item's result is produced.
    a_write_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> load && (act_reg == ACT_WRITE))
        else $error("frame memory written outside an execute cycle");

    // A new result appears only after an execute cycle.
    a_result_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result word raised without an execute cycle");

    // Flipped pixels always flag a redraw.
    a_changed_redraw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (out_reg.changed_bits != 4'd0) |-> out_reg.redraw)
        else $error("changed pixels reported without redraw");

endmodule

// ===== sim/lcd_frame_store_with_scroll_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_frame_store_with_scroll_core_tb
// Self-checking testbench for the LCD frame store with per-controller scroll.
// Every input word that the core accepts goes through a local model of the
// panel. The model covers the frame memory, the display enables, the start
// lines, the pixel balance and the backlight level. The expected status word
// is queued, and each result word is compared field by field with the oldest
// queued status word. The stimulus has four parts: a short directed sequence,
// a fill of the whole panel, a long output stall, and a random mix. Both
// sides of the core idle and stall at random.
// ----------------------------------------------------------------------------
module lcd_frame_store_with_scroll_core_tb;
    import lcdfs_pkg::*;

    // Codes above the defined actions, which must leave the state alone.
    localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] ACT_RESERVED_LAST  = 3'd7;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_REPORTS    = 10;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // column[6:0], page[9:7], byte_data[17:10], controller[18], enable[19],
    // start_line[25:20], screen_line[31:26], backlight_in[39:32]
    logic [39:0] s_tdata  = '0;
    // action[2:0]
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // pixel[0], changed_bits[4:1], pixel_balance[18:5], redraw[19],
    // light_on_dark[20], backlight_level[28:21], zero[31:29]
    logic [31:0] m_tdata;

    // Local copy of the panel state.
    logic [7:0]          frame_shadow [MEM_DEPTH];
    logic [NUM_CTRL-1:0] enabled_shadow;
    logic [5:0]          start_shadow [NUM_CTRL];
    int                  balance_shadow;
    logic [7:0]          backlight_shadow;

    out_word_t panel_status_q [$];

    int error_count    = 0;
    int results_seen   = 0;
    int idle_cycles    = 0;
    bit sender_gaps_on = 1'b0;
    bit sink_stalls_on = 1'b0;
    bit hold_request   = 1'b0;
    int rx_pause_left  = 0;
    int last_write_col = 0;

    lcd_frame_store_with_scroll_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Mostly short gaps before the next word, now and then a long one.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic int stall_length();
        if ($urandom_range(99) < 85) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic string show_status(input out_word_t o);
        return $sformatf("pix=%0d chg=%0d bal=%0d redraw=%0d lod=%0d bl=%0d pad=%0d",
                         o.pixel, o.changed_bits, o.pixel_balance, o.redraw,
                         o.light_on_dark, o.backlight_level, o.pad);
    endfunction

    // Clears the local panel state to its power-up values.
    function automatic void reset_shadow();
        foreach (frame_shadow[i]) frame_shadow[i] = 8'h00;
        foreach (start_shadow[i]) start_shadow[i] = 6'd0;
        enabled_shadow   = '0;
        balance_shadow   = -(PANEL_PIXELS / 2);
        backlight_shadow = BACKLIGHT_RESET;
    endfunction

    // Applies one word to the local panel state and returns the status the
    // core should report for it.
    function automatic out_word_t predict_panel_status(input logic [2:0] act,
                                                       input in_word_t w);
        out_word_t  o;
        int         addr;
        int         row;
        int         ctrl;
        int         lit_on;
        int         lit_off;
        int         shown;
        logic [7:0] old;
        o = '0;
        case (act)
            ACT_WRITE: begin
                addr    = w.column * PAGES + w.page;
                old     = frame_shadow[addr];
                lit_on  = $countones(w.byte_data & ~old);
                lit_off = $countones(old & ~w.byte_data);
                frame_shadow[addr] = w.byte_data;
                balance_shadow += lit_on - lit_off;
                o.changed_bits = 4'(lit_on + lit_off);
                o.redraw       = (lit_on + lit_off) != 0;
            end
            ACT_ENABLE: begin
                if (enabled_shadow[w.controller] != w.enable) begin
                    enabled_shadow[w.controller] = w.enable;
                    o.redraw = 1'b1;
                end
            end
            ACT_START: begin
                if (start_shadow[w.controller] != w.start_line) begin
                    start_shadow[w.controller] = w.start_line;
                    o.redraw = 1'b1;
                end
            end
            ACT_READ: begin
                // The shown line wraps around the controller's 64 rows.
                ctrl = w.column / CTRL_COLUMNS;
                if (enabled_shadow[ctrl]) begin
                    row = (w.screen_line + start_shadow[ctrl]) % CTRL_ROWS;
                    old = frame_shadow[w.column * PAGES + row / 8];
                    o.pixel = old[row % 8];
                end
            end
            ACT_BACKLIGHT: begin
                if (backlight_shadow != w.backlight_in) begin
                    backlight_shadow = w.backlight_in;
                    o.redraw = 1'b1;
                end
            end
            default: ;
        endcase
        shown = balance_shadow;
        if (shown < SAT_MIN) shown = SAT_MIN;
        if (shown > SAT_MAX) shown = SAT_MAX;
        o.pixel_balance   = 14'(shown);
        o.light_on_dark   = (balance_shadow < 0) || !(&enabled_shadow);
        o.backlight_level = backlight_shadow;
        return o;
    endfunction

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    // Offers one word, waits for the handshake, then predicts its status.
    task automatic send_item(input logic [2:0] act, input in_word_t w);
        int gap;
        s_tuser  <= act;
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        panel_status_q.push_back(predict_panel_status(act, w));
        gap = sender_gaps_on ? sender_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic in_word_t random_fields();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[39:0];
    endfunction

    task automatic do_write(input int col, input int pg, input int data);
        in_word_t w;
        w = random_fields();
        w.column    = 7'(col);
        w.page      = 3'(pg);
        w.byte_data = 8'(data);
        send_item(ACT_WRITE, w);
    endtask

    task automatic do_read(input int col, input int line);
        in_word_t w;
        w = random_fields();
        w.column      = 7'(col);
        w.screen_line = 6'(line);
        send_item(ACT_READ, w);
    endtask

    task automatic do_enable(input int ctrl, input int en);
        in_word_t w;
        w = random_fields();
        w.controller = 1'(ctrl);
        w.enable     = 1'(en);
        send_item(ACT_ENABLE, w);
    endtask

    task automatic do_start(input int ctrl, input int line);
        in_word_t w;
        w = random_fields();
        w.controller = 1'(ctrl);
        w.start_line = 6'(line);
        send_item(ACT_START, w);
    endtask

    task automatic do_backlight(input int level);
        in_word_t w;
        w = random_fields();
        w.backlight_in = 8'(level);
        send_item(ACT_BACKLIGHT, w);
    endtask

    // One random word, weighted toward writes and reads. Reads often land on
    // the column that was written last, and enables mostly switch on.
    task automatic send_random_item();
        in_word_t   w;
        logic [2:0] act;
        int         r;
        w = random_fields();
        r = $urandom_range(99);
        if (r < 40) begin
            act = ACT_WRITE;
            case ($urandom_range(3))
                0: w.byte_data = 8'h00;
                1: w.byte_data = 8'hFF;
                default: ;
            endcase
            last_write_col = w.column;
        end else if (r < 70) begin
            act = ACT_READ;
            if ($urandom_range(1)) w.column = 7'(last_write_col);
        end else if (r < 78) begin
            act = ACT_ENABLE;
            w.enable = $urandom_range(3) != 0;
        end else if (r < 88) begin
            act = ACT_START;
        end else if (r < 96) begin
            act = ACT_BACKLIGHT;
        end else begin
            act = 3'($urandom_range(ACT_RESERVED_LAST, ACT_RESERVED_FIRST));
        end
        send_item(act, w);
    endtask

    // Lowers valid and waits until every queued status word has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (panel_status_q.size() != 0) @(posedge aclk);
    endtask

    // Extremes of every field, each action, no-change writes, scroll
    // wrap-around, the controller boundary, and reads from a switched-off
    // controller.
    task automatic test_directed();
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        do_read(5, 0);
        send_item(ACT_RESERVED_FIRST, random_fields());
        send_item(ACT_RESERVED_LAST, random_fields());
        do_backlight(0);
        do_backlight(255);
        do_backlight(255);
        do_enable(0, 1);
        do_enable(1, 1);
        do_enable(1, 1);
        do_write(0, 0, 8'hFF);
        do_write(0, 0, 8'hFF);
        do_read(0, 0);
        do_write(127, 7, 8'hFF);
        do_write(127, 7, 8'hA5);
        do_start(1, 63);
        do_start(1, 63);
        do_read(127, 0);
        do_read(127, 63);
        do_write(63, 3, 8'h01);
        do_write(64, 3, 8'h80);
        do_read(64, 32);
        do_start(0, 1);
        do_read(0, 63);
        do_enable(0, 0);
        do_read(0, 63);
        do_write(0, 0, 8'h00);
        do_start(1, 0);
        do_enable(0, 1);
        do_backlight(16);
    endtask

    // Lights every pixel, so the balance climbs to its highest value, with
    // reads and scroll changes in between.
    task automatic test_fill_panel();
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        for (int a = 0; a < MEM_DEPTH; a++) begin
            if (a == MEM_DEPTH / 4) begin
                sender_gaps_on = 1'b1;
                sink_stalls_on = 1'b1;
            end
            do_write(a / PAGES, a % PAGES, 8'hFF);
            if (a % 8 == 7)
                do_read($urandom_range(PANEL_COLUMNS - 1), $urandom_range(PANEL_ROWS - 1));
            if (a % 128 == 127)
                do_start($urandom_range(NUM_CTRL - 1), $urandom_range(CTRL_ROWS - 1));
        end
        do_enable(1, 0);
        do_read(100, 10);
        do_enable(1, 1);
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the core backs up and stalls its input.
    task automatic test_output_stall();
        sender_gaps_on = 1'b0;
        hold_request   = 1'b1;
        repeat (40) send_random_item();
        wait_drained();
        sender_gaps_on = 1'b1;
    endtask

    task automatic test_random_mix(input int count);
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i == 60) begin
                sender_gaps_on = 1'b1;
                sink_stalls_on = 1'b1;
            end
            send_random_item();
        end
    endtask

    // Result side: random stalls, plus one long hold when the test asks.
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request  = 1'b0;
            rx_pause_left = LONG_HOLD;
        end
        if (rx_pause_left > 0) begin
            rx_pause_left--;
            m_tready <= 1'b0;
        end else if (sink_stalls_on && $urandom_range(99) < 30) begin
            rx_pause_left = stall_length() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result word with the oldest queued status word.
    always @(posedge aclk) begin
        out_word_t got;
        out_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (panel_status_q.size() == 0) begin
                log_error($sformatf("result %0d arrived with nothing queued: %s",
                                    results_seen, show_status(got)));
            end else begin
                want = panel_status_q.pop_front();
                if (got.pixel !== want.pixel || got.changed_bits !== want.changed_bits ||
                    got.pixel_balance !== want.pixel_balance ||
                    got.redraw !== want.redraw ||
                    got.light_on_dark !== want.light_on_dark ||
                    got.backlight_level !== want.backlight_level ||
                    got.pad !== want.pad)
                    log_error($sformatf("result %0d mismatch: expected %s, got %s",
                                        results_seen, show_status(want),
                                        show_status(got)));
            end
        end
    end

    // Ends the run if neither side moves a word for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lcd_frame_store_with_scroll_core regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reset_shadow();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_fill_panel();
        test_output_stall();
        test_random_mix(320);
        wait_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && panel_status_q.size() == 0)
            $display("lcd_frame_store_with_scroll_core regression: pass");
        else
            $display("lcd_frame_store_with_scroll_core regression: fail");
        $finish;
    end

endmodule
